@@ rtl/core/plid_pkg.sv @@
// Shared constants and types for the positional list block.
package plid_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int ELEM_W   = 32;

  localparam logic [2:0] K_INS_FRONT = 3'd0;
  localparam logic [2:0] K_INS_BACK  = 3'd1;
  localparam logic [2:0] K_INS_AT    = 3'd2;
  localparam logic [2:0] K_DEL_FRONT = 3'd3;
  localparam logic [2:0] K_DEL_BACK  = 3'd4;
  localparam logic [2:0] K_DEL_AT    = 3'd5;
  localparam logic [2:0] K_DUMP      = 3'd6;
  localparam logic [2:0] K_UNUSED    = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] wrap_pos;
    elem_t            ins_value;
    elem_t            wrap_value;
  } cell_ctl_t;

endpackage

@@ rtl/core/plid_cell.sv @@
// One storage cell of the list chain, shifting to or from its neighbors.
module plid_cell (
  input  logic                      clk,
  input  plid_pkg::cell_ctl_t       ctl,
  input  logic [plid_pkg::IDX_W-1:0] cell_idx,
  input  plid_pkg::elem_t           left_val,
  input  plid_pkg::elem_t           right_val,
  output plid_pkg::elem_t           val
);

  plid_pkg::elem_t val_r;
  plid_pkg::elem_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      plid_pkg::OP_INSERT: begin
        if (cell_idx == ctl.pos) begin
          val_nxt = ctl.ins_value;
        end else if (cell_idx > ctl.pos) begin
          val_nxt = left_val;
        end
      end
      plid_pkg::OP_DELETE: begin
        if (cell_idx >= ctl.pos) begin
          val_nxt = right_val;
        end
      end
      plid_pkg::OP_ROTATE: begin
        if (cell_idx == ctl.wrap_pos) begin
          val_nxt = ctl.wrap_value;
        end else begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ rtl/core/positional_list_insert_delete.sv @@
// Top level of the positional list: request decode, cell chain and result register.
//
// The list lives in a chain of CAPACITY cells. An insert or delete beat shifts every cell
// behind the position at once, so such beats can arrive every cycle while the result
// register drains. A dump emits one beat per stored element: the chain rotates one step per
// emitted beat and is back in order after the last one, and no input beat is taken until
// the dump is done. No clearing pass follows reset.
module positional_list_insert_delete (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // value[31:0], index[39:32]
  input  logic [2:0]  in_tuser,  // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // status[1:0], position[9:2], element[41:10], zeros
  output logic        out_tlast
);

  localparam logic [2:0] K_INS_FRONT = plid_pkg::K_INS_FRONT;
  localparam logic [2:0] K_INS_BACK  = plid_pkg::K_INS_BACK;
  localparam logic [2:0] K_INS_AT    = plid_pkg::K_INS_AT;
  localparam logic [2:0] K_DEL_FRONT = plid_pkg::K_DEL_FRONT;
  localparam logic [2:0] K_DEL_BACK  = plid_pkg::K_DEL_BACK;
  localparam logic [2:0] K_DEL_AT    = plid_pkg::K_DEL_AT;
  localparam logic [2:0] K_DUMP      = plid_pkg::K_DUMP;

  localparam logic [1:0] STAT_OK    = plid_pkg::STAT_OK;
  localparam logic [1:0] STAT_EMPTY = plid_pkg::STAT_EMPTY;
  localparam logic [1:0] STAT_BAD   = plid_pkg::STAT_BAD;
  localparam logic [1:0] STAT_FULL  = plid_pkg::STAT_FULL;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  localparam int CAP = plid_pkg::CAPACITY;
  localparam int IW  = plid_pkg::IDX_W;
  localparam int CW  = plid_pkg::CNT_W;
  localparam int PW  = plid_pkg::POS_W;

  logic                state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       dump_idx_r, dump_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [PW-1:0]       out_pos_r, out_pos_nxt;
  plid_pkg::elem_t     out_elem_r, out_elem_nxt;
  logic                out_last_r, out_last_nxt;

  plid_pkg::cell_ctl_t ctl;
  plid_pkg::elem_t     cell_val [CAP];

  logic                out_free;
  logic                accept;
  logic [2:0]          kind;
  plid_pkg::elem_t     value;
  logic [PW-1:0]       index;
  logic [PW-1:0]       count_ext;
  logic [CW-1:0]       count_m1;
  logic [PW-1:0]       req_pos;
  logic [1:0]          req_status;
  logic                dump_last;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign kind      = in_tuser;
  assign value     = in_tdata[31:0];
  assign index     = in_tdata[39:32];
  assign count_ext = PW'(count_r);
  assign count_m1  = count_r - CW'(1);
  assign dump_last = (CW'(dump_idx_r) == count_m1);

  always_comb begin
    req_pos    = '0;
    req_status = STAT_OK;
    case (kind)
      K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
        if (kind == K_INS_FRONT) begin
          req_pos = '0;
        end else if (kind == K_INS_BACK) begin
          req_pos = count_ext;
        end else begin
          req_pos = index;
        end
        if (req_pos > count_ext) begin
          req_status = STAT_BAD;
        end else if (count_r == CW'(CAP)) begin
          req_status = STAT_FULL;
        end
      end
      K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: begin
        if (kind == K_DEL_FRONT) begin
          req_pos = '0;
        end else if (kind == K_DEL_BACK) begin
          req_pos = (count_r != '0) ? PW'(count_m1) : '0;
        end else begin
          req_pos = index;
        end
        if (count_r == '0) begin
          req_status = STAT_EMPTY;
        end else if (req_pos >= count_ext) begin
          req_status = STAT_BAD;
        end
      end
      default: begin
        req_pos    = '0;
        req_status = (count_r == '0) ? STAT_EMPTY : STAT_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_elem_nxt   = out_elem_r;
    out_last_nxt   = out_last_r;
    ctl.op         = plid_pkg::OP_HOLD;
    ctl.pos        = req_pos[IW-1:0];
    ctl.wrap_pos   = count_m1[IW-1:0];
    ctl.ins_value  = value;
    ctl.wrap_value = cell_val[0];

    if (state_r == S_IDLE) begin
      if (accept) begin
        case (kind)
          K_INS_FRONT, K_INS_BACK, K_INS_AT, K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = req_status;
            out_pos_nxt    = (req_status == STAT_OK) ? req_pos : '0;
            out_elem_nxt   = '0;
            out_last_nxt   = 1'b1;
            if (req_status == STAT_OK) begin
              if (kind inside {K_INS_FRONT, K_INS_BACK, K_INS_AT}) begin
                ctl.op    = plid_pkg::OP_INSERT;
                count_nxt = count_r + CW'(1);
              end else begin
                ctl.op    = plid_pkg::OP_DELETE;
                count_nxt = count_m1;
              end
            end
          end
          K_DUMP: begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
              out_pos_nxt    = '0;
              out_elem_nxt   = '0;
              out_last_nxt   = 1'b1;
            end else begin
              state_nxt    = S_DUMP;
              dump_idx_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end else if (out_free) begin
      ctl.op         = plid_pkg::OP_ROTATE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_OK;
      out_pos_nxt    = PW'(dump_idx_r);
      out_elem_nxt   = cell_val[0];
      out_last_nxt   = dump_last;
      dump_idx_nxt   = dump_idx_r + IW'(1);
      if (dump_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    plid_pkg::elem_t left_w;
    plid_pkg::elem_t right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_val[0];
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right_w = cell_val[g];
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end
    plid_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (IW'(g)),
      .left_val  (left_w),
      .right_val (right_w),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_elem_r   <= out_elem_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_elem_r, out_pos_r, out_status_r};
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("element count above capacity");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !in_tready)
    else $error("input taken during a dump");

  a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> $stable(count_r))
    else $error("element count changed during a dump");

  a_dump_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (CW'(dump_idx_r) < count_r))
    else $error("dump position beyond the list");

endmodule

@@ test/positional_list_insert_delete_tb.sv @@
// Testbench for the positional list: directed and random requests checked against a list model.
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;

  localparam logic [2:0] KIND_INSERT_FRONT = plid_pkg::K_INS_FRONT;
  localparam logic [2:0] KIND_INSERT_BACK  = plid_pkg::K_INS_BACK;
  localparam logic [2:0] KIND_INSERT_AT    = plid_pkg::K_INS_AT;
  localparam logic [2:0] KIND_DELETE_FRONT = plid_pkg::K_DEL_FRONT;
  localparam logic [2:0] KIND_DELETE_BACK  = plid_pkg::K_DEL_BACK;
  localparam logic [2:0] KIND_DELETE_AT    = plid_pkg::K_DEL_AT;
  localparam logic [2:0] KIND_DUMP         = plid_pkg::K_DUMP;
  localparam logic [2:0] KIND_UNUSED       = plid_pkg::K_UNUSED;

  localparam logic [1:0] STATUS_OK        = plid_pkg::STAT_OK;
  localparam logic [1:0] STATUS_EMPTY     = plid_pkg::STAT_EMPTY;
  localparam logic [1:0] STATUS_BAD_INDEX = plid_pkg::STAT_BAD;
  localparam logic [1:0] STATUS_FULL      = plid_pkg::STAT_FULL;

  localparam int LONG_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES    = plid_pkg::CAPACITY + 8;
  localparam int RANDOM_REQUESTS  = 400;

  typedef struct packed {
    logic [1:0]      status;
    logic [7:0]      position;
    plid_pkg::elem_t element;
    logic            last;
  } list_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // value[31:0], index[39:32]
  logic [2:0]  in_tuser;   // kind[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // status[1:0], position[9:2], element[41:10], zeros
  logic        out_tlast;

  plid_pkg::elem_t list_cells [plid_pkg::CAPACITY];
  int              list_len;
  list_result_t    pending_results [$];
  int              error_count;
  bit              sender_idle;
  bit              receiver_idle;
  bit              long_hold_req;

  positional_list_insert_delete dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic predict_request(input logic [2:0] kind, input plid_pkg::elem_t value,
                                 input logic [7:0] at_index);
    list_result_t r;
    int pos;
    r = '0;
    r.last = 1'b1;
    case (kind)
      KIND_INSERT_FRONT, KIND_INSERT_BACK, KIND_INSERT_AT: begin
        pos = (kind == KIND_INSERT_FRONT) ? 0 :
              (kind == KIND_INSERT_BACK) ? list_len : int'(at_index);
        if (pos > list_len) begin
          r.status = STATUS_BAD_INDEX;
        end else if (list_len >= plid_pkg::CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = value;
          list_len++;
          r.status = STATUS_OK;
          r.position = pos[7:0];
        end
        pending_results.push_back(r);
      end
      KIND_DELETE_FRONT, KIND_DELETE_BACK, KIND_DELETE_AT: begin
        pos = (kind == KIND_DELETE_FRONT) ? 0 :
              (kind == KIND_DELETE_BACK) ? list_len - 1 : int'(at_index);
        if (list_len == 0) begin
          r.status = STATUS_EMPTY;
        end else if (pos >= list_len) begin
          r.status = STATUS_BAD_INDEX;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
          r.status = STATUS_OK;
          r.position = pos[7:0];
        end
        pending_results.push_back(r);
      end
      KIND_DUMP: begin
        if (list_len == 0) begin
          r.status = STATUS_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.status = STATUS_OK;
            r.position = i[7:0];
            r.element = list_cells[i];
            r.last = (i + 1 == list_len);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [2:0] kind, input plid_pkg::elem_t value,
                              input logic [7:0] at_index);
    int gap;
    gap = sender_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {at_index, value};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    predict_request(kind, value, at_index);
  endtask

  task automatic wait_until_drained();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_results.size() > 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_request(KIND_DUMP, 0, 8'd0);
    send_request(KIND_DELETE_FRONT, 0, 8'd0);
    send_request(KIND_DELETE_BACK, 0, 8'd0);
    send_request(KIND_DELETE_AT, 0, 8'd0);
    send_request(KIND_DELETE_AT, 0, 8'd255);
    send_request(KIND_INSERT_AT, 32'sd5, 8'd1);
    send_request(KIND_INSERT_AT, 32'sd6, 8'd255);
  endtask

  task automatic test_basic_edits();
    send_request(KIND_INSERT_FRONT, 32'sh8000_0000, 8'd0);
    send_request(KIND_INSERT_BACK, 32'sh7FFF_FFFF, 8'd0);
    send_request(KIND_INSERT_AT, 32'sd0, 8'd1);
    send_request(KIND_INSERT_AT, -32'sd1, 8'd3);
    send_request(KIND_DELETE_AT, 0, 8'd4);
    send_request(KIND_DUMP, 0, 8'd0);
    send_request(KIND_UNUSED, 32'sd99, 8'd0);
    send_request(KIND_DELETE_AT, 0, 8'd1);
    send_request(KIND_DELETE_FRONT, 0, 8'd0);
    send_request(KIND_DELETE_BACK, 0, 8'd0);
    send_request(KIND_DELETE_BACK, 0, 8'd0);
    send_request(KIND_DUMP, 0, 8'd0);
  endtask

  task automatic test_full_list();
    logic [2:0] kind;
    while (list_len < plid_pkg::CAPACITY) begin
      kind = 3'($urandom_range(0, 2));
      send_request(kind, plid_pkg::elem_t'($urandom), 8'($urandom_range(0, list_len)));
    end
    send_request(KIND_INSERT_FRONT, 32'sd1, 8'd0);
    send_request(KIND_INSERT_AT, 32'sd2, 8'(plid_pkg::CAPACITY + 1));
    send_request(KIND_INSERT_AT, 32'sd3, 8'(plid_pkg::CAPACITY));
    send_request(KIND_INSERT_BACK, 32'sd4, 8'd0);
    send_request(KIND_DUMP, 0, 8'd0);
    send_request(KIND_DELETE_AT, 0, 8'(plid_pkg::CAPACITY - 1));
    send_request(KIND_DELETE_AT, 0, 8'd0);
    send_request(KIND_DUMP, 0, 8'd0);
  endtask

  task automatic test_backpressure();
    logic [2:0] kind;
    long_hold_req = 1'b1;
    for (int n = 0; n < 24; n++) begin
      if (n % 8 == 7) begin
        kind = KIND_DUMP;
      end else begin
        kind = 3'($urandom_range(0, 5));
      end
      send_request(kind, plid_pkg::elem_t'($urandom), 8'($urandom_range(0, list_len)));
    end
  endtask

  task automatic test_random_edits(input int count);
    logic [2:0] kind;
    logic [7:0] at_index;
    int issued;
    int pick;
    bit grow;
    issued = 0;
    grow = 1'b1;
    while (issued < count) begin
      if (issued % 110 == 0) begin
        sender_idle = 1'($urandom_range(0, 1));
        receiver_idle = 1'($urandom_range(0, 1));
      end
      if (list_len >= plid_pkg::CAPACITY) begin
        grow = 1'b0;
      end else if (list_len == 0) begin
        grow = 1'b1;
      end else if ($urandom_range(0, 40) == 0) begin
        grow = !grow;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        kind = KIND_UNUSED;
      end else if (pick < 10) begin
        kind = KIND_DUMP;
      end else if (pick < (grow ? 80 : 35)) begin
        kind = 3'($urandom_range(0, 2));
      end else begin
        kind = 3'($urandom_range(3, 5));
      end
      if ($urandom_range(0, 9) == 0) begin
        at_index = 8'($urandom_range(0, 255));
      end else if (kind <= KIND_INSERT_AT) begin
        at_index = 8'($urandom_range(0, list_len));
      end else begin
        at_index = 8'($urandom_range(0, (list_len > 0) ? list_len : 0));
      end
      send_request(kind, plid_pkg::elem_t'($urandom), at_index);
      if (kind != KIND_UNUSED) issued++;
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) stall_left = receiver_idle ? $urandom_range(0, 6) : 0;
      if (long_hold_req) begin
        stall_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = out_tdata[1:0];
      got.position = out_tdata[9:2];
      got.element  = out_tdata[41:10];
      got.last     = out_tlast;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Unexpected beat: status %0d position %0d element %0d last %0d",
                   got.status, got.position, got.element, got.last);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Mismatch: expected status %0d position %0d element %0d last %0d",
                     want.status, want.position, want.element, want.last);
            $display("          actual   status %0d position %0d element %0d last %0d",
                     got.status, got.position, got.element, got.last);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    list_len = 0;
    error_count = 0;
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    test_basic_edits();
    sender_idle = 1'b0;
    test_full_list();
    sender_idle = 1'b1;
    receiver_idle = 1'b0;
    test_backpressure();
    test_random_edits(RANDOM_REQUESTS);

    wait_until_drained();
    if (pending_results.size() > 0) error_count += pending_results.size();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/plid_pkg.sv
rtl/core/plid_cell.sv
rtl/core/positional_list_insert_delete.sv
test/positional_list_insert_delete_tb.sv
